// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; the checks compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check sampled on clk, ignored while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check sampled on clk, also active during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// Types, constants and helpers for the streaming first-match search.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int MAX_PAT = 16;                 // longest pattern in bytes
  localparam int WIN_LEN = MAX_PAT - 1;        // bytes held in the window
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 16;                 // position counter width
  localparam int LEN_W   = $clog2(MAX_PAT + 1);
  localparam int PIDX_W  = $clog2(MAX_PAT);    // index into the pattern
  localparam int CFG_W   = 64;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef logic [BYTE_W-1:0]              byte_t;
  typedef logic [MAX_PAT-1:0][BYTE_W-1:0] pat_t;
  typedef logic [LEN_W-1:0]               len_t;
  typedef logic [IDX_W-1:0]               idx_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // length in use: clamp to MAX_PAT, then stop at the first zero byte
  function automatic len_t eff_len(pat_t pat, len_t plen);
    len_t clamp;
    len_t res;
    clamp = (plen > len_t'(MAX_PAT)) ? len_t'(MAX_PAT) : plen;
    res   = clamp;
    for (int k = MAX_PAT - 1; k >= 0; k--) begin
      if ((len_t'(k) < clamp) && (pat[k] == '0)) begin
        res = len_t'(k);
      end
    end
    return res;
  endfunction

endpackage

// File: src/sfm_cell.sv
// ----------------------------------------------------------------------------
// sfm_cell
// One window cell: holds a text byte, hands it on to the next cell on each
// shift, and compares it against the pattern byte aligned to it.
// ----------------------------------------------------------------------------
module sfm_cell import sfm_pkg::*; (
  input  logic  clk,
  input  logic  shift_en,
  input  byte_t shift_in,
  input  logic  used,       // cell falls inside the current pattern span
  input  byte_t expected,   // pattern byte aligned with this cell
  output byte_t shift_out,
  output logic  ok
);

  byte_t data_r;

  // window byte, shifted in from the younger neighbor
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= shift_in;
    end
  end

  assign shift_out = data_r;

  // unused cells never block a match
  assign ok = !used || (data_r == expected);

endmodule

// File: src/substring_first_match.sv
// ----------------------------------------------------------------------------
// substring_first_match
// Streaming search for the first occurrence of a pattern in a byte text.
// ----------------------------------------------------------------------------
// Takes one text byte per clock cycle while in_stall is low; in_stall rises
// when a held result word meets out_stall. The whole pattern is checked
// combinationally against a row of 15 window cells plus the incoming byte,
// with any result registered to the output in the cycle after acceptance.
// A zero byte ends a text. A text gives one word: found=1 with the start
// position of the first hit, or found=0 at the terminator. An empty pattern
// hits at position 0 on the first byte. Positions stop at 65535 and then set
// index_saturated. Write the pattern registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module substring_first_match import sfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_write_en,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // text in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  // result out
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_match_index,
  output logic              out_index_saturated
);

  // configuration registers
  logic [CFG_W-1:0] pat_low_r;
  logic [CFG_W-1:0] pat_high_r;
  len_t             pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  pat_t pat;
  len_t plen;
  assign pat  = pat_t'({pat_high_r, pat_low_r});
  assign plen = eff_len(pat, pat_len_r);

  // handshake: take a word whenever the output register is free or draining
  logic out_valid_r;
  logic acc;
  logic is_term;
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign is_term  = (in_text_byte == '0);

  // per-text state
  idx_t bytes_seen_r;
  idx_t bytes_seen_nxt;
  logic reported_r;
  logic reported_nxt;

  // window: a row of cells, cell 0 holds the newest byte
  byte_t            cell_byte [WIN_LEN];
  logic [WIN_LEN-1:0] cell_ok;
  logic             shift_en;
  assign shift_en = acc && !is_term;

  for (genvar w = 0; w < WIN_LEN; w++) begin : g_cell
    len_t  off;
    logic  used;
    byte_t expected;
    byte_t shift_in;

    // cell w lines up with pattern byte len-2-w
    assign used     = (plen >= len_t'(w + 2));
    assign off      = plen - len_t'(w + 2);
    assign expected = pat[off[PIDX_W-1:0]];

    if (w == 0) begin : g_head
      assign shift_in = in_text_byte;
    end else begin : g_link
      assign shift_in = cell_byte[w-1];
    end

    sfm_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .shift_in  (shift_in),
      .used      (used),
      .expected  (expected),
      .shift_out (cell_byte[w]),
      .ok        (cell_ok[w])
    );
  end

  // match decision for the incoming byte
  len_t  last_off;
  logic  enough;
  logic  hit;
  logic  sat;
  assign last_off = plen - len_t'(1);
  assign enough   = ({1'b0, bytes_seen_r} + (IDX_W+1)'(1)) >= (IDX_W+1)'(plen);
  assign hit      = (pat[last_off[PIDX_W-1:0]] == in_text_byte) && (&cell_ok);
  assign sat      = (bytes_seen_r == IDX_MAX);

  logic res_valid;
  logic res_found;
  idx_t res_index;
  logic res_sat;

  always_comb begin
    res_valid = 1'b0;
    res_found = 1'b0;
    res_index = '0;
    res_sat   = 1'b0;
    if (!reported_r && (plen == '0)) begin
      // empty pattern hits at the start
      res_valid = 1'b1;
      res_found = 1'b1;
    end else if (!reported_r && is_term) begin
      // text ended without a hit
      res_valid = 1'b1;
      res_sat   = sat;
    end else if (!reported_r && !is_term && enough && hit) begin
      res_valid = 1'b1;
      res_found = 1'b1;
      res_sat   = sat;
      res_index = sat ? IDX_MAX : (bytes_seen_r + idx_t'(1) - idx_t'(plen));
    end
  end

  // per-text state update
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    reported_nxt   = reported_r;
    if (acc) begin
      if (is_term) begin
        bytes_seen_nxt = '0;
        reported_nxt   = 1'b0;
      end else begin
        reported_nxt = reported_r || res_valid;
        if (!sat) begin
          bytes_seen_nxt = bytes_seen_r + idx_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      reported_r   <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      reported_r   <= reported_nxt;
    end
  end

  // output register
  logic out_valid_nxt;
  assign out_valid_nxt = acc ? res_valid : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  logic out_found_r;
  idx_t out_index_r;
  logic out_sat_r;

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      out_found_r <= res_found;
      out_index_r <= res_index;
      out_sat_r   <= res_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_match_index     = out_index_r;
  assign out_index_saturated = out_sat_r;

  // checks
  `ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> out_valid_r, "stall without held word")
  `ASSERT_CLK(a_miss_has_zero_index, (out_valid_r && !out_found_r) |-> (out_index_r == '0),
              "miss word carries nonzero index")
  `ASSERT_CLK(a_sat_hit_index, (out_valid_r && out_found_r && out_sat_r) |-> (out_index_r == IDX_MAX),
              "saturated hit with wrong index")
  `ASSERT_CLK(a_term_clears, (acc && is_term) |=> (bytes_seen_r == '0 && !reported_r),
              "terminator did not clear text state")
  `ASSERT_CLK(a_count_monotonic, (acc && !is_term) |=> (bytes_seen_r >= $past(bytes_seen_r)),
              "position counter went backwards")

endmodule
